// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; assumes clk and rst_n are in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check of a property on every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge out of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fqs_pkg.sv =====
// Shared types and constants for the searchable queue.
package fqs_pkg;

  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic                     was_empty;
    logic                     overflow;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                     upd;      // item accepted this cycle
    logic                     shift;    // pop: take neighbour's word
    logic                     load;     // push: cell at tail takes operand
    logic                     find;     // search this item
    logic signed [DATA_W-1:0] operand;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/fqs_cell.sv =====
// One storage cell of the queue chain: word register plus comparator.
module fqs_cell #(
  parameter int IDX    = 0,
  parameter int CNT_W  = 5
) (
  input  logic                             clk,
  input  fqs_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                 cnt,
  input  logic signed [fqs_pkg::DATA_W-1:0] next_data,
  output logic signed [fqs_pkg::DATA_W-1:0] data,
  output logic                             match
);

  logic signed [fqs_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                              match_r, match_nxt;
  logic                              occupied;
  logic                              at_tail;

  assign occupied = CNT_W'(IDX) < cnt;
  assign at_tail  = cnt == CNT_W'(IDX);

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.load && at_tail) begin
      data_nxt = ctrl.operand;
    end
    if (ctrl.upd) begin
      match_nxt = ctrl.find && occupied && (data_r == ctrl.operand);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ===== rtl/core/fifo_queue_with_search.sv =====
// Searchable FIFO queue of signed 32-bit words built as a chain of cells.
//
// Input channel (in_valid/in_stall/in_item): one opcode and operand per item:
// push, pop, find or clear. Every accepted item yields exactly one result
// item on the output channel (out_valid/out_stall/out_item).
// Queue state (words and count) is updated at the accepting edge, where each
// cell also registers its own compare and the item's pending result is
// registered; the match bits are ORed into the output register when that
// pending result advances.
// Throughput: one item per cycle while the receiver takes results; the
// per-cell comparators and the shifting chain set that figure.
// When the receiver stalls, the output register holds its result and one
// more item may be accepted into the pending stage; after that in_stall
// rises until the output frees.
// Reset (rst_n low, synchronous) empties the queue and drops any results in
// flight. Word contents are not cleared; only cells below the count are read.
module fifo_queue_with_search #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fqs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output fqs_pkg::out_item_t out_item
);

  `include "assert_macros.svh"

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int OccW = fqs_pkg::OCC_W;
  localparam int DW   = fqs_pkg::DATA_W;

  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  fqs_pkg::out_item_t  pend_item_r, pend_item_nxt;
  logic                out_valid_r, out_valid_nxt;
  fqs_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                accept;
  logic                advance;
  logic                empty;
  logic                full;
  fqs_pkg::cell_ctrl_t ctrl;

  logic signed [DW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]     match_w;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == CntW'(DEPTH);
  assign advance = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && out_valid_r && out_stall;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    ctrl.upd     = accept;
    ctrl.shift   = accept && (in_item.opcode == fqs_pkg::OP_POP) && !empty;
    ctrl.load    = accept && (in_item.opcode == fqs_pkg::OP_PUSH) && !full;
    ctrl.find    = in_item.opcode == fqs_pkg::OP_FIND;
    ctrl.operand = in_item.operand_value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int Nb = (i == DEPTH - 1) ? i : i + 1;
    fqs_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cnt       (cnt_r),
      .next_data (cell_data[Nb]),
      .data      (cell_data[i]),
      .match     (match_w[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      case (in_item.opcode)
        fqs_pkg::OP_PUSH:  if (!full) cnt_nxt = cnt_r + CntW'(1);
        fqs_pkg::OP_POP:   if (!empty) cnt_nxt = cnt_r - CntW'(1);
        fqs_pkg::OP_FIND:  cnt_nxt = cnt_r;
        fqs_pkg::OP_CLEAR: cnt_nxt = '0;
        default:           cnt_nxt = cnt_r;
      endcase
    end
  end

  always_comb begin
    pend_item_nxt = pend_item_r;
    if (accept) begin
      pend_item_nxt.popped_value = ctrl.shift ? cell_data[0] : '0;
      pend_item_nxt.found        = 1'b0;  // filled from the match bits later
      pend_item_nxt.was_empty    = empty;
      pend_item_nxt.overflow     = (in_item.opcode == fqs_pkg::OP_PUSH) && full;
      pend_item_nxt.occupancy    = OccW'(cnt_nxt);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (advance) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (advance) begin
      out_valid_nxt      = 1'b1;
      out_item_nxt       = pend_item_r;
      out_item_nxt.found = |match_w;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_item_r <= pend_item_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_CLK(a_cnt_bound, (cnt_r <= CntW'(DEPTH)), "queue count beyond depth")
  `ASSERT_IMP(a_clear_empties, accept && (in_item.opcode == fqs_pkg::OP_CLEAR), ##1 (cnt_r == '0), "clear left words in queue")
  `ASSERT_IMP(a_full_push_holds, accept && (in_item.opcode == fqs_pkg::OP_PUSH) && full, ##1 (cnt_r == $past(cnt_r)), "dropped push changed count")
  `ASSERT_IMP(a_result_follows, accept, ##1 pend_r, "accepted item not pending")
  `ASSERT_IMP(a_found_only_nonempty, advance && (match_w != '0), !pend_item_r.was_empty, "match reported on empty queue")

endmodule
